// ===== design/udrlb_pkg.sv =====
// shared types, constants and helpers of the dual ring line buffer
package udrlb_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W = $clog2(RING_DEPTH);

  localparam int BYTE_W = 8;
  localparam int LINE_COUNT_W = 12;
  localparam int LINE_LIMIT_W = 13;

  localparam logic [LINE_LIMIT_W-1:0] LINE_LIMIT_RESET = 13'd256;
  localparam logic [LINE_LIMIT_W-1:0] LINE_LIMIT_MAX = 13'd4096;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  // configuration register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_LINE_LIMIT = 3'd0;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    MODE_RX_PUSH   = 2'd0,
    MODE_TX_POP    = 2'd1,
    MODE_TX_PUSH   = 2'd2,
    MODE_LINE_READ = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ENDED = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [BYTE_W-1:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]       out_byte;
    logic                    byte_valid;
    logic [1:0]              status;
    logic [LINE_COUNT_W-1:0] line_length;
  } rsp_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] data;
  } ring_cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [BYTE_W-1:0] head;
  } ring_stat_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

// ===== design/udrlb_ring.sv =====
// one ring buffer: byte store, pointers and read-ahead head register
module udrlb_ring (
  input  logic                   clk,
  input  logic                   rst,
  input  udrlb_pkg::ring_cmd_t   cmd,
  output udrlb_pkg::ring_stat_t  stat
);

  udrlb_pkg::ptr_t wr_ptr;
  udrlb_pkg::ptr_t wr_ptr_next;
  udrlb_pkg::ptr_t rd_ptr;
  udrlb_pkg::ptr_t rd_ptr_next;
  logic [udrlb_pkg::BYTE_W-1:0] store [udrlb_pkg::RING_DEPTH];
  logic [udrlb_pkg::BYTE_W-1:0] head;

  always_comb begin
    wr_ptr_next = cmd.push ? udrlb_pkg::ring_next(wr_ptr) : wr_ptr;
    rd_ptr_next = cmd.pop ? udrlb_pkg::ring_next(rd_ptr) : rd_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  // read ahead at the next read pointer, write-first so the head tracks a fresh push
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[wr_ptr] <= cmd.data;
    end
    if (cmd.push && (wr_ptr == rd_ptr_next)) begin
      head <= cmd.data;
    end else begin
      head <= store[rd_ptr_next];
    end
  end

  always_comb begin
    stat.empty = (rd_ptr == wr_ptr);
    stat.full  = (udrlb_pkg::ring_next(wr_ptr) == rd_ptr);
    stat.head  = head;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("push into a full ring");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("pop from an empty ring");

  a_head_after_push_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && !cmd.pop && stat.empty) |=> (stat.head == $past(cmd.data) && !stat.empty))
    else $error("head register missed a push into an empty ring");

  a_pop_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop && !cmd.push) |=> !stat.full)
    else $error("ring still full after a pop");
`endif

endmodule

// ===== design/udrlb_step.sv =====
// per-item decode: ring commands, line count update and result fields
module udrlb_step (
  input  udrlb_pkg::req_t                            item,
  input  udrlb_pkg::ring_stat_t                      rx_stat,
  input  udrlb_pkg::ring_stat_t                      tx_stat,
  input  logic [udrlb_pkg::LINE_COUNT_W-1:0]         line_count,
  input  logic [udrlb_pkg::LINE_LIMIT_W-1:0]         line_limit,
  output udrlb_pkg::ring_cmd_t                       rx_cmd,
  output udrlb_pkg::ring_cmd_t                       tx_cmd,
  output logic [udrlb_pkg::LINE_COUNT_W-1:0]         line_count_next,
  output udrlb_pkg::rsp_t                            rsp
);

  logic [udrlb_pkg::LINE_COUNT_W-1:0] lim_m1;
  logic [udrlb_pkg::LINE_COUNT_W-1:0] count_inc;
  logic                               is_term;

  // clamp the limit into 1..4096 and take off one
  always_comb begin
    if (line_limit == '0) begin
      lim_m1 = '0;
    end else if (line_limit > udrlb_pkg::LINE_LIMIT_MAX) begin
      lim_m1 = udrlb_pkg::LINE_COUNT_W'(udrlb_pkg::LINE_LIMIT_MAX - 13'd1);
    end else begin
      lim_m1 = udrlb_pkg::LINE_COUNT_W'(line_limit - 13'd1);
    end
  end

  assign count_inc = line_count + 12'd1;
  assign is_term = (rx_stat.head == udrlb_pkg::CH_CR) || (rx_stat.head == udrlb_pkg::CH_LF);

  always_comb begin
    rx_cmd          = '{push: 1'b0, pop: 1'b0, data: item.data_byte};
    tx_cmd          = '{push: 1'b0, pop: 1'b0, data: item.data_byte};
    line_count_next = line_count;
    rsp.out_byte    = '0;
    rsp.byte_valid  = 1'b0;
    rsp.status      = udrlb_pkg::ST_OK;
    rsp.line_length = line_count;
    unique case (item.mode)
      udrlb_pkg::MODE_RX_PUSH: begin
        if (rx_stat.full) begin
          rsp.status = udrlb_pkg::ST_FULL;
        end else begin
          rx_cmd.push = 1'b1;
        end
      end
      udrlb_pkg::MODE_TX_PUSH: begin
        if (tx_stat.full) begin
          rsp.status = udrlb_pkg::ST_FULL;
        end else begin
          tx_cmd.push = 1'b1;
        end
      end
      udrlb_pkg::MODE_TX_POP: begin
        if (tx_stat.empty) begin
          rsp.status = udrlb_pkg::ST_EMPTY;
        end else begin
          tx_cmd.pop     = 1'b1;
          rsp.out_byte   = tx_stat.head;
          rsp.byte_valid = 1'b1;
        end
      end
      udrlb_pkg::MODE_LINE_READ: begin
        if (line_count >= lim_m1) begin
          rsp.status      = udrlb_pkg::ST_ENDED;
          line_count_next = '0;
        end else if (rx_stat.empty) begin
          rsp.status = udrlb_pkg::ST_EMPTY;
        end else begin
          rx_cmd.pop = 1'b1;
          if (is_term) begin
            rsp.status      = udrlb_pkg::ST_ENDED;
            line_count_next = '0;
          end else begin
            rsp.out_byte    = rx_stat.head;
            rsp.byte_valid  = 1'b1;
            line_count_next = count_inc;
            rsp.line_length = count_inc;
          end
        end
      end
    endcase
  end

endmodule

// ===== design/uart_dual_ring_line_buffer.sv =====
// top level of the dual ring line buffer: handshakes, config register and the two rings
// Receive and transmit byte rings with a line reader on the receive side. An item
// goes into the input register, is resolved in a single pass against the two rings
// and the line count, and lands in the result register, which drives the result
// port; one item is taken per cycle when the result side does not stall; the rate
// is set by the one write port and one registered read port of each ring store.
// Each ring keeps 256 entries and holds at most 255 bytes; its read port reads
// ahead at the next read pointer, so the oldest byte always sits in a register,
// ready for a pop. The stores need no clearing pass after reset. Modes: 0 push a
// received byte, 1 pop a byte to transmit, 2 queue a byte to transmit, 3 read one
// line byte (CR or LF ends the line and is swallowed, and reaching line_limit
// minus one bytes ends it without consuming anything). A push into a full ring is
// dropped with status 3. line_limit lives at address 0 of the register port; the
// user must write it only while the block is idle, which the block does not enforce.
module uart_dual_ring_line_buffer (
  input  logic                              clk,
  input  logic                              rst,
  // item channel in
  input  logic                              req_valid,
  output logic                              req_stall,
  input  udrlb_pkg::req_t                   req_item,
  // result channel out
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output udrlb_pkg::rsp_t                   rsp_item,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [udrlb_pkg::PADDR_W-1:0]     paddr,
  input  logic [udrlb_pkg::PDATA_W-1:0]     pwdata,
  output logic [udrlb_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  // input register
  logic            req_q_valid;
  udrlb_pkg::req_t req_q;
  logic            accept;
  logic            fire;

  // state
  logic [udrlb_pkg::LINE_COUNT_W-1:0] line_count;
  logic [udrlb_pkg::LINE_COUNT_W-1:0] line_count_next;
  logic [udrlb_pkg::LINE_LIMIT_W-1:0] line_limit;

  // single pass outputs
  udrlb_pkg::ring_cmd_t  rx_cmd;
  udrlb_pkg::ring_cmd_t  tx_cmd;
  udrlb_pkg::ring_cmd_t  rx_cmd_gated;
  udrlb_pkg::ring_cmd_t  tx_cmd_gated;
  udrlb_pkg::ring_stat_t rx_stat;
  udrlb_pkg::ring_stat_t tx_stat;
  udrlb_pkg::rsp_t       rsp_next;

  logic cfg_write;
  logic cfg_hit;

  // an item is resolved when the result register is free or being emptied
  assign fire      = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !fire;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_item;
    end
  end

  udrlb_step u_step (
    .item            (req_q),
    .rx_stat         (rx_stat),
    .tx_stat         (tx_stat),
    .line_count      (line_count),
    .line_limit      (line_limit),
    .rx_cmd          (rx_cmd),
    .tx_cmd          (tx_cmd),
    .line_count_next (line_count_next),
    .rsp             (rsp_next)
  );

  // ring commands only take effect when the item really goes through
  always_comb begin
    rx_cmd_gated      = rx_cmd;
    tx_cmd_gated      = tx_cmd;
    rx_cmd_gated.push = rx_cmd.push && fire;
    rx_cmd_gated.pop  = rx_cmd.pop && fire;
    tx_cmd_gated.push = tx_cmd.push && fire;
    tx_cmd_gated.pop  = tx_cmd.pop && fire;
  end

  udrlb_ring u_rx_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (rx_cmd_gated),
    .stat (rx_stat)
  );

  udrlb_ring u_tx_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (tx_cmd_gated),
    .stat (tx_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (fire) begin
      line_count <= line_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_item <= rsp_next;
    end
  end

  // register port, no wait states
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr == udrlb_pkg::ADDR_LINE_LIMIT);
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= udrlb_pkg::LINE_LIMIT_RESET;
    end else if (cfg_write) begin
      line_limit <= pwdata[udrlb_pkg::LINE_LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = udrlb_pkg::PDATA_W'(line_limit);
    end
  end

endmodule
